>>> rtl/core/assert_macros.svh
// assertion helpers, clocked on clk_i and quiet while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define AST_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition never holds
`define AST_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("assertion failed");

`endif

>>> rtl/core/yrd_pkg.sv
package yrd_pkg;

  localparam int unsigned MAX_CLASSES = 128;
  localparam int unsigned FRAC_BITS   = 12;
  // scale registers are Q4.12 regardless of the element format
  localparam int unsigned SCALE_FRAC  = 12;

  localparam int unsigned ELEM_W     = 24;
  localparam int unsigned THR_W      = 13;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CLASS_W    = 8;
  localparam int unsigned POS_W      = 8;
  localparam int unsigned BOX_W      = 16;
  localparam int unsigned CPX_W      = 32;
  localparam int unsigned SCORE_W    = 24;
  localparam int unsigned AREA_W     = 48;

  localparam int unsigned OBJ_POS     = 4;
  localparam int unsigned FIRST_CLASS = 5;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(2048);
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(4096);

  localparam int unsigned MUL_W  = 28;
  localparam int unsigned PROD_W = 2 * MUL_W;

  localparam int unsigned ROWQ_DEPTH = 2;
  localparam int unsigned ROWQ_AW    = $clog2(ROWQ_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONF_THR = 2'd0,
    CFG_SCALE_X  = 2'd1,
    CFG_SCALE_Y  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    STEP_SCORE,
    STEP_WIDTH,
    STEP_HEIGHT,
    STEP_CX,
    STEP_CY,
    STEP_LEFT,
    STEP_TOP,
    STEP_AREA
  } mul_step_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_LAST,
    BK_DONE
  } bk_state_e;

  typedef struct packed {
    logic signed [ELEM_W-1:0] cx;
    logic signed [ELEM_W-1:0] cy;
    logic signed [ELEM_W-1:0] w;
    logic signed [ELEM_W-1:0] h;
    logic signed [ELEM_W-1:0] obj;
    logic signed [ELEM_W-1:0] best;
    logic [CLASS_W-1:0]       cls;
  } row_rec_t;

  localparam row_rec_t ROW_CLEAR = '{
    cx: '0, cy: '0, w: '0, h: '0, obj: '0, best: '0, cls: '1
  };

  typedef struct packed {
    logic [THR_W-1:0]   thr;
    logic [SCALE_W-1:0] sx;
    logic [SCALE_W-1:0] sy;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // arithmetic shift right that rounds toward zero
  function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] x,
                                                   input int unsigned k);
    logic signed [63:0] bias;
    bias = (x < 0) ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (x + bias) >>> k;
  endfunction

  function automatic logic signed [63:0] sat_s(input logic signed [63:0] x,
                                               input int unsigned bits);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (x > hi) begin
      return hi;
    end else if (x < lo) begin
      return lo;
    end
    return x;
  endfunction

endpackage

>>> rtl/core/yrd_front.sv
module yrd_front import yrd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [ELEM_W-1:0] element_value_i,
  input  logic                     row_last_i,
  input  q_stat_t                  q_stat_i,
  output logic                     push_o,
  output row_rec_t                 push_rec_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  row_rec_t         row_q, row_d;
  logic [POS_W:0]   cls_off;
  logic             is_class;
  logic             fire;

  // only a row end needs a free queue slot
  assign in_ready_o = !(row_last_i && q_stat_i.full);
  assign fire       = in_valid_i && in_ready_o;

  assign cls_off  = {1'b0, pos_q} - (POS_W+1)'(FIRST_CLASS);
  assign is_class = (pos_q >= POS_W'(FIRST_CLASS)) && (pos_q != POS_MAX) &&
                    (cls_off < (POS_W+1)'(MAX_CLASSES));

  always_comb begin
    row_d = row_q;
    if (pos_q < POS_W'(OBJ_POS)) begin
      case (pos_q[1:0])
        2'd0:    row_d.cx = element_value_i;
        2'd1:    row_d.cy = element_value_i;
        2'd2:    row_d.w  = element_value_i;
        2'd3:    row_d.h  = element_value_i;
        default: row_d.h  = element_value_i;
      endcase
    end else if (pos_q == POS_W'(OBJ_POS)) begin
      row_d.obj = element_value_i;
    end else if (is_class && (element_value_i > row_q.best)) begin
      // first strictly greater score wins
      row_d.best = element_value_i;
      row_d.cls  = cls_off[CLASS_W-1:0];
    end
    pos_d = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      row_q <= ROW_CLEAR;
    end else if (fire) begin
      if (row_last_i) begin
        pos_q <= '0;
        row_q <= ROW_CLEAR;
      end else begin
        pos_q <= pos_d;
        row_q <= row_d;
      end
    end
  end

  assign push_o     = fire && row_last_i;
  assign push_rec_o = row_d;

endmodule

>>> rtl/core/yrd_queue.sv
module yrd_queue import yrd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  row_rec_t push_rec_i,
  input  logic     pop_i,
  output row_rec_t head_o,
  output q_stat_t  stat_o
);

  row_rec_t             mem_q [ROWQ_DEPTH];
  row_rec_t             head_q;
  logic [ROWQ_AW-1:0]   wr_q, rd_q;
  logic [ROWQ_AW:0]     cnt_q;

  // head is registered; the back end always passes through its idle state before it reads it
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_rec_i;
    end
    head_q <= mem_q[rd_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign head_o       = head_q;
  assign stat_o.full  = (cnt_q == (ROWQ_AW+1)'(ROWQ_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

>>> rtl/core/yrd_back.sv
module yrd_back import yrd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  q_stat_t                   q_stat_i,
  input  row_rec_t                  head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [BOX_W-1:0]   box_left_o,
  output logic signed [BOX_W-1:0]   box_top_o,
  output logic signed [BOX_W-1:0]   box_width_o,
  output logic signed [BOX_W-1:0]   box_height_o,
  output logic signed [CPX_W-1:0]   center_px_x_o,
  output logic signed [CPX_W-1:0]   center_px_y_o,
  output logic [SCORE_W-1:0]        score_o,
  output logic signed [CLASS_W-1:0] class_index_o,
  output logic signed [AREA_W-1:0]  box_area_o
);

  bk_state_e state_q, state_d;
  mul_step_e step_q, pstep_q;
  logic      pval_q;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [MUL_W-1:0]  dx, dy;
  logic signed [PROD_W-1:0] prod_q;

  logic signed [MUL_W-1:0]   wq_q, hq_q;
  logic signed [BOX_W-1:0]   left_q, top_q, width_q, height_q;
  logic signed [CPX_W-1:0]   cpx_q, cpy_q;
  logic [SCORE_W-1:0]        score_q;
  logic signed [AREA_W-1:0]  area_q;

  logic signed [BOX_W-1:0]   out_left_q, out_top_q, out_width_q, out_height_q;
  logic signed [CPX_W-1:0]   out_cpx_q, out_cpy_q;
  logic [SCORE_W-1:0]        out_score_q;
  logic [CLASS_W-1:0]        out_cls_q;
  logic signed [AREA_W-1:0]  out_area_q;
  logic                      out_valid_q;

  logic signed [63:0] p64, obj64, thr64, sc64;
  logic signed [63:0] q_scale, q_box, q_edge, q_area;
  logic signed [63:0] s_box, s_edge, s_cpx, s_area;
  logic               drop, abort, out_free;
  logic               issue, load_out, st_pop;

  // ---------------- multiplier operand select ----------------
  // twice the center minus the size, so left/top divide by one more bit
  assign dx = (MUL_W'(head_i.cx) <<< 1) - MUL_W'(head_i.w);
  assign dy = (MUL_W'(head_i.cy) <<< 1) - MUL_W'(head_i.h);

  always_comb begin
    case (step_q)
      STEP_SCORE: begin
        mul_a = MUL_W'(head_i.obj);
        mul_b = MUL_W'(head_i.best);
      end
      STEP_WIDTH: begin
        mul_a = MUL_W'(head_i.w);
        mul_b = MUL_W'(cfg_i.sx);
      end
      STEP_HEIGHT: begin
        mul_a = MUL_W'(head_i.h);
        mul_b = MUL_W'(cfg_i.sy);
      end
      STEP_CX: begin
        mul_a = MUL_W'(head_i.cx);
        mul_b = MUL_W'(cfg_i.sx);
      end
      STEP_CY: begin
        mul_a = MUL_W'(head_i.cy);
        mul_b = MUL_W'(cfg_i.sy);
      end
      STEP_LEFT: begin
        mul_a = dx;
        mul_b = MUL_W'(cfg_i.sx);
      end
      STEP_TOP: begin
        mul_a = dy;
        mul_b = MUL_W'(cfg_i.sy);
      end
      STEP_AREA: begin
        mul_a = wq_q;
        mul_b = hq_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ---------------- product post-processing ----------------
  assign p64   = 64'(prod_q);
  assign obj64 = 64'(head_i.obj);
  assign thr64 = $signed(64'(cfg_i.thr));

  assign drop = ((obj64 <<< SCALE_FRAC) < (thr64 <<< FRAC_BITS)) ||
                ((p64 <<< SCALE_FRAC) < (thr64 <<< (2 * FRAC_BITS)));

  assign sc64    = p64 >>> FRAC_BITS;
  assign q_scale = trunc_shr(p64, SCALE_FRAC);
  assign q_box   = trunc_shr(p64, FRAC_BITS + SCALE_FRAC);
  assign q_edge  = trunc_shr(p64, FRAC_BITS + SCALE_FRAC + 1);
  assign q_area  = trunc_shr(p64, 2 * FRAC_BITS);
  assign s_box   = sat_s(q_box, BOX_W);
  assign s_edge  = sat_s(q_edge, BOX_W);
  assign s_cpx   = sat_s(q_scale, CPX_W);
  assign s_area  = sat_s(q_area, AREA_W);

  assign abort    = pval_q && (pstep_q == STEP_SCORE) && drop;
  assign out_free = !out_valid_q || out_ready_i;

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_stat_i.empty) begin
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (abort) begin
          state_d = BK_IDLE;
        end else if (step_q == STEP_AREA) begin
          state_d = BK_LAST;
        end
      end
      BK_LAST: state_d = BK_DONE;
      BK_DONE: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    issue    = 1'b0;
    load_out = 1'b0;
    st_pop   = 1'b0;
    case (state_q)
      BK_RUN:  issue = 1'b1;
      BK_DONE: begin
        load_out = out_free;
        st_pop   = out_free;
      end
      default: begin
        issue    = 1'b0;
        load_out = 1'b0;
        st_pop   = 1'b0;
      end
    endcase
  end

  assign pop_o = st_pop || abort;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      step_q      <= STEP_SCORE;
      pstep_q     <= STEP_SCORE;
      pval_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pval_q  <= issue && !abort;
      if (issue) begin
        pstep_q <= step_q;
        step_q  <= mul_step_e'(3'(step_q + 3'd1));
      end else begin
        step_q <= STEP_SCORE;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      prod_q <= mul_a * mul_b;
    end
    if (pval_q) begin
      case (pstep_q)
        STEP_SCORE: begin
          if (sc64 < 0) begin
            score_q <= '0;
          end else if (sc64 > 64'(2 ** SCORE_W - 1)) begin
            score_q <= '1;
          end else begin
            score_q <= sc64[SCORE_W-1:0];
          end
        end
        STEP_WIDTH: begin
          width_q <= s_box[BOX_W-1:0];
          wq_q    <= q_scale[MUL_W-1:0];
        end
        STEP_HEIGHT: begin
          height_q <= s_box[BOX_W-1:0];
          hq_q     <= q_scale[MUL_W-1:0];
        end
        STEP_CX:   cpx_q  <= s_cpx[CPX_W-1:0];
        STEP_CY:   cpy_q  <= s_cpx[CPX_W-1:0];
        STEP_LEFT: left_q <= s_edge[BOX_W-1:0];
        STEP_TOP:  top_q  <= s_edge[BOX_W-1:0];
        STEP_AREA: area_q <= s_area[AREA_W-1:0];
        default:   area_q <= area_q;
      endcase
    end
    if (load_out) begin
      out_left_q   <= left_q;
      out_top_q    <= top_q;
      out_width_q  <= width_q;
      out_height_q <= height_q;
      out_cpx_q    <= cpx_q;
      out_cpy_q    <= cpy_q;
      out_score_q  <= score_q;
      out_cls_q    <= head_i.cls;
      out_area_q   <= area_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign box_left_o    = out_left_q;
  assign box_top_o     = out_top_q;
  assign box_width_o   = out_width_q;
  assign box_height_o  = out_height_q;
  assign center_px_x_o = out_cpx_q;
  assign center_px_y_o = out_cpy_q;
  assign score_o       = out_score_q;
  assign class_index_o = $signed(out_cls_q);
  assign box_area_o    = out_area_q;

endmodule

>>> rtl/core/yolo_row_decode_core.sv
// channel   | signals                                   | direction
// ----------+-------------------------------------------+----------
// in        | in_valid_i/in_ready_o, element_value_i,   | request in
//           | row_last_i                                |
// out       | out_valid_o/out_ready_i, box_*, center_*, | request out
//           | score_o, class_index_o, box_area_o        |
// cfg       | cfg_we_i, cfg_idx_i, cfg_wdata_i          | write only
//
// front takes one element per cycle; it holds off only a row's last element
// while the two-entry row queue is full.
// back runs eight products through one shared 28x28 multiplier, in the steps score, width,
// height, cx, cy, left, top and area; a dropped row ends after the score step.
// reset loads the config defaults and clears row state; there is no clearing pass.
// a finished result sits in the output register while the front keeps filling.
`include "assert_macros.svh"

module yolo_row_decode_core import yrd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [ELEM_W-1:0]  element_value_i,
  input  logic                      row_last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [BOX_W-1:0]   box_left_o,
  output logic signed [BOX_W-1:0]   box_top_o,
  output logic signed [BOX_W-1:0]   box_width_o,
  output logic signed [BOX_W-1:0]   box_height_o,
  output logic signed [CPX_W-1:0]   center_px_x_o,
  output logic signed [CPX_W-1:0]   center_px_y_o,
  output logic [SCORE_W-1:0]        score_o,
  output logic signed [CLASS_W-1:0] class_index_o,
  output logic signed [AREA_W-1:0]  box_area_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata_i
);

  cfg_t     cfg_q;
  q_stat_t  q_stat;
  row_rec_t push_rec, head_rec;
  logic     push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thr <= THR_RESET;
      cfg_q.sx  <= SCALE_RESET;
      cfg_q.sy  <= SCALE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CONF_THR: cfg_q.thr <= cfg_wdata_i[THR_W-1:0];
        CFG_SCALE_X:  cfg_q.sx  <= cfg_wdata_i[SCALE_W-1:0];
        CFG_SCALE_Y:  cfg_q.sy  <= cfg_wdata_i[SCALE_W-1:0];
        default:      cfg_q     <= cfg_q;
      endcase
    end
  end

  yrd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .element_value_i (element_value_i),
    .row_last_i      (row_last_i),
    .q_stat_i        (q_stat),
    .push_o          (push),
    .push_rec_o      (push_rec)
  );

  yrd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .head_o     (head_rec),
    .stat_o     (q_stat)
  );

  yrd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_stat_i      (q_stat),
    .head_i        (head_rec),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .box_left_o    (box_left_o),
    .box_top_o     (box_top_o),
    .box_width_o   (box_width_o),
    .box_height_o  (box_height_o),
    .center_px_x_o (center_px_x_o),
    .center_px_y_o (center_px_y_o),
    .score_o       (score_o),
    .class_index_o (class_index_o),
    .box_area_o    (box_area_o)
  );

  `AST_NEVER(a_q_full_and_empty, q_stat.full && q_stat.empty)
  `AST_IMPL(a_no_push_when_full, push, !q_stat.full)
  `AST_IMPL(a_no_pop_when_empty, pop, !q_stat.empty)

endmodule

>>> test/row_decode_compare.sv
`timescale 1ns / 100ps

module row_decode_compare import yrd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic signed [ELEM_W-1:0]  element_value_i,
  input  logic                      row_last_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic signed [BOX_W-1:0]   box_left_i,
  input  logic signed [BOX_W-1:0]   box_top_i,
  input  logic signed [BOX_W-1:0]   box_width_i,
  input  logic signed [BOX_W-1:0]   box_height_i,
  input  logic signed [CPX_W-1:0]   center_px_x_i,
  input  logic signed [CPX_W-1:0]   center_px_y_i,
  input  logic [SCORE_W-1:0]        score_i,
  input  logic signed [CLASS_W-1:0] class_index_i,
  input  logic signed [AREA_W-1:0]  box_area_i,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata_i,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        checked_o,
  output int                        dropped_o
);

  // threshold register is Q1.12 no matter what the element format is
  localparam int unsigned THR_FRAC = 12;
  localparam longint THR_ONE   = 64'sd1 <<< THR_FRAC;
  localparam longint ELEM_ONE  = 64'sd1 <<< FRAC_BITS;
  localparam longint SCALE_ONE = 64'sd1 <<< SCALE_FRAC;
  localparam longint SCORE_MAX = (64'sd1 <<< SCORE_W) - 64'sd1;

  typedef struct packed {
    logic signed [BOX_W-1:0]   left;
    logic signed [BOX_W-1:0]   top;
    logic signed [BOX_W-1:0]   width;
    logic signed [BOX_W-1:0]   height;
    logic signed [CPX_W-1:0]   ctr_x;
    logic signed [CPX_W-1:0]   ctr_y;
    logic [SCORE_W-1:0]        score;
    logic signed [CLASS_W-1:0] cls;
    logic signed [AREA_W-1:0]  area;
  } detection_t;

  detection_t expected_dets[$];

  logic [POS_W-1:0]         elem_pos;
  logic signed [ELEM_W-1:0] box_raw [4];
  logic signed [ELEM_W-1:0] obj_level;
  logic signed [ELEM_W-1:0] best_score;
  logic [CLASS_W-1:0]       best_class;
  logic [THR_W-1:0]         conf_thr;
  logic [SCALE_W-1:0]       scale_x;
  logic [SCALE_W-1:0]       scale_y;

  function automatic longint clamp_to(input longint v, input int bits);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
    if (v > hi) begin
      return hi;
    end
    if (v < -hi - 64'sd1) begin
      return -hi - 64'sd1;
    end
    return v;
  endfunction

  task automatic clear_row_state();
    elem_pos   = '0;
    for (int i = 0; i < 4; i++) begin
      box_raw[i] = '0;
    end
    obj_level  = '0;
    best_score = '0;
    best_class = '1;
  endtask

  task automatic take_element(input logic signed [ELEM_W-1:0] v, input logic is_last);
    int         p;
    longint     thr, obj, best, prod, cx, cy, w, h, sx, sy, wq, hq, sc;
    detection_t det;
    p = int'(elem_pos);
    if (p < int'(OBJ_POS)) begin
      box_raw[p] = v;
    end else if (p == int'(OBJ_POS)) begin
      obj_level = v;
    end else if (p < int'(POS_MAX) && p < int'(FIRST_CLASS + MAX_CLASSES)) begin
      // first strictly greater score wins
      if (v > best_score) begin
        best_score = v;
        best_class = CLASS_W'(p - int'(FIRST_CLASS));
      end
    end
    if (p < int'(POS_MAX)) begin
      elem_pos = elem_pos + 1'b1;
    end
    if (!is_last) begin
      return;
    end

    thr  = longint'(conf_thr);
    obj  = longint'(obj_level);
    best = longint'(best_score);
    prod = obj * best;
    if (obj * THR_ONE < thr * ELEM_ONE || prod * THR_ONE < thr * ELEM_ONE * ELEM_ONE) begin
      dropped_o++;
      clear_row_state();
      return;
    end

    cx = longint'(box_raw[0]);
    cy = longint'(box_raw[1]);
    w  = longint'(box_raw[2]);
    h  = longint'(box_raw[3]);
    sx = longint'(scale_x);
    sy = longint'(scale_y);

    // corner is center minus half size, so one more bit of divide
    det.left   = BOX_W'(clamp_to(((2 * cx - w) * sx) / (2 * ELEM_ONE * SCALE_ONE), BOX_W));
    det.top    = BOX_W'(clamp_to(((2 * cy - h) * sy) / (2 * ELEM_ONE * SCALE_ONE), BOX_W));
    det.width  = BOX_W'(clamp_to((w * sx) / (ELEM_ONE * SCALE_ONE), BOX_W));
    det.height = BOX_W'(clamp_to((h * sy) / (ELEM_ONE * SCALE_ONE), BOX_W));
    det.ctr_x  = CPX_W'(clamp_to((cx * sx) / SCALE_ONE, CPX_W));
    det.ctr_y  = CPX_W'(clamp_to((cy * sy) / SCALE_ONE, CPX_W));

    sc = prod >>> FRAC_BITS;
    if (sc > SCORE_MAX) begin
      sc = SCORE_MAX;
    end
    if (sc < 0) begin
      sc = 0;
    end
    det.score = SCORE_W'(sc);
    det.cls   = best_class;

    // area from the scaled sizes, each cut to element precision first
    wq = (w * sx) / SCALE_ONE;
    hq = (h * sy) / SCALE_ONE;
    det.area = AREA_W'(clamp_to((wq * hq) / (ELEM_ONE * ELEM_ONE), AREA_W));

    expected_dets = {expected_dets, det};
    clear_row_state();
  endtask

  task automatic match_field(input string name, input longint want, input longint got);
    if (want != got) begin
      fail_count_o++;
      $display("%0t ns mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    detection_t det;
    if (!rst_ni) begin
      conf_thr = THR_RESET;
      scale_x  = SCALE_RESET;
      scale_y  = SCALE_RESET;
      clear_row_state();
      expected_dets.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      dropped_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CONF_THR: conf_thr = cfg_wdata_i[THR_W-1:0];
          CFG_SCALE_X:  scale_x  = cfg_wdata_i[SCALE_W-1:0];
          CFG_SCALE_Y:  scale_y  = cfg_wdata_i[SCALE_W-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        take_element(element_value_i, row_last_i);
      end

      if (out_valid_i && out_ready_i) begin
        if (expected_dets.size() == 0) begin
          fail_count_o++;
          $display("%0t ns unexpected detection: expected none, actual class %0d score %0d",
                   $time, class_index_i, score_i);
        end else begin
          det = expected_dets.pop_front();
          checked_o++;
          match_field("box_left", det.left, box_left_i);
          match_field("box_top", det.top, box_top_i);
          match_field("box_width", det.width, box_width_i);
          match_field("box_height", det.height, box_height_i);
          match_field("center_px_x", det.ctr_x, center_px_x_i);
          match_field("center_px_y", det.ctr_y, center_px_y_i);
          match_field("score", longint'(det.score), longint'(score_i));
          match_field("class_index", det.cls, class_index_i);
          match_field("box_area", det.area, box_area_i);
        end
      end

      pending_o = expected_dets.size();
    end
  end

endmodule

>>> test/yolo_row_decode_core_test.sv
`timescale 1ns / 100ps

module yolo_row_decode_core_test;
  import yrd_pkg::*;

  localparam int RESET_CYCLES  = 4;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 120;
  localparam int QUIET_LIMIT   = 5000;
  localparam int PHASE_ITEMS   = 130;
  localparam int PHASES        = 6;
  localparam int IDLE_PCT      = 35;
  localparam int ONE_Q         = 1 << FRAC_BITS;

  // index past the register list, the block must ignore it
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [ELEM_W-1:0]  element_value = '0;
  logic                      row_last = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [BOX_W-1:0]   box_left, box_top, box_width, box_height;
  logic signed [CPX_W-1:0]   center_px_x, center_px_y;
  logic [SCORE_W-1:0]        score;
  logic signed [CLASS_W-1:0] class_index;
  logic signed [AREA_W-1:0]  box_area;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx = CFG_CONF_THR;
  logic [CFG_DATA_W-1:0]     cfg_wdata = '0;

  int fail_count, pending, dets_checked, rows_dropped;
  int quiet_cycles = 0;
  int elements_sent = 0;
  int rows_sent = 0;
  int settings_used = 1;
  int cur_thr = int'(THR_RESET);
  bit quiet_phase = 1'b0;
  bit hold_req = 1'b0;

  logic signed [ELEM_W-1:0] row_buf[$];

  yolo_row_decode_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .element_value_i (element_value),
    .row_last_i      (row_last),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .box_left_o      (box_left),
    .box_top_o       (box_top),
    .box_width_o     (box_width),
    .box_height_o    (box_height),
    .center_px_x_o   (center_px_x),
    .center_px_y_o   (center_px_y),
    .score_o         (score),
    .class_index_o   (class_index),
    .box_area_o      (box_area),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  row_decode_compare u_compare (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .element_value_i (element_value),
    .row_last_i      (row_last),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .box_left_i      (box_left),
    .box_top_i       (box_top),
    .box_width_i     (box_width),
    .box_height_i    (box_height),
    .center_px_x_i   (center_px_x),
    .center_px_y_i   (center_px_y),
    .score_i         (score),
    .class_index_i   (class_index),
    .box_area_i      (box_area),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (dets_checked),
    .dropped_o       (rows_dropped)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver side, with one long hold-off so the row queue fills up
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= quiet_phase || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
    end
    $display("%0t ns watchdog: no request moved for %0d cycles", $time, QUIET_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic signed [ELEM_W-1:0] wild_elem();
    return ELEM_W'($urandom());
  endfunction

  function automatic logic signed [ELEM_W-1:0] box_elem();
    int r;
    r = $urandom_range(99);
    if (r < 75) begin
      return ELEM_W'($urandom_range(0, 640 * ONE_Q));
    end else if (r < 85) begin
      return ELEM_W'(-int'($urandom_range(0, 64 * ONE_Q)));
    end
    return wild_elem();
  endfunction

  // mostly at or above threshold so that rows get through
  function automatic logic signed [ELEM_W-1:0] obj_elem(input int thr);
    int r;
    r = $urandom_range(99);
    if (r < 70) begin
      return ELEM_W'(thr + int'($urandom_range(0, 2 * ONE_Q)));
    end else if (r < 85) begin
      return ELEM_W'($urandom_range(0, thr));
    end
    return wild_elem();
  endfunction

  function automatic logic signed [ELEM_W-1:0] score_elem();
    if ($urandom_range(99) < 80) begin
      return ELEM_W'(int'($urandom_range(0, 3 * ONE_Q)) - ONE_Q);
    end
    return wild_elem();
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_element(input logic signed [ELEM_W-1:0] v, input logic is_last);
    while (!quiet_phase && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    element_value <= v;
    row_last      <= is_last;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    elements_sent++;
    @(negedge clk);
  endtask

  task automatic send_row();
    for (int i = 0; i < row_buf.size(); i++) begin
      send_element(row_buf[i], i == row_buf.size() - 1);
    end
    rows_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // drain all detections, then give dropped rows time to leave the back end
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_config(input int thr, input int sx, input int sy);
    write_reg(CFG_CONF_THR, thr);
    write_reg(CFG_SCALE_X, sx);
    write_reg(CFG_SCALE_Y, sy);
    cur_thr = thr;
    settings_used++;
  endtask

  initial begin
    int n;
    int phase_items;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // box extremes, score saturates
    row_buf = '{ELEM_MAX, ELEM_MIN, ELEM_MAX, ELEM_MIN, ELEM_MAX, ELEM_MAX};
    send_row();
    // short row, missing elements read as zero
    row_buf = '{ELEM_W'(100 * ONE_Q)};
    send_row();
    // objectness and product both exactly on the threshold
    row_buf = '{ELEM_W'(100 * ONE_Q), ELEM_W'(50 * ONE_Q), ELEM_W'(20 * ONE_Q),
                ELEM_W'(10 * ONE_Q), ELEM_W'(ONE_Q / 2), ELEM_W'(ONE_Q)};
    send_row();
    // product one step under the threshold
    row_buf = '{ELEM_W'(100 * ONE_Q), ELEM_W'(50 * ONE_Q), ELEM_W'(20 * ONE_Q),
                ELEM_W'(10 * ONE_Q), ELEM_W'(ONE_Q / 2), ELEM_W'(ONE_Q - 1)};
    send_row();
    // tie on the best score keeps the earlier class
    row_buf = '{ELEM_W'(-3 * ONE_Q), ELEM_W'(7 * ONE_Q), ELEM_W'(ONE_Q), ELEM_W'(-ONE_Q),
                ELEM_W'(ONE_Q), ELEM_W'(3000), ELEM_W'(5000), ELEM_W'(5000)};
    send_row();

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: apply_config(0, 16'hFFFF, 16'hFFFF);
        1: apply_config(ONE_Q, 0, 0);
        4: begin
          apply_config($urandom_range(0, ONE_Q), ONE_Q, 1);
          write_reg(CFG_IDX_SPARE, $urandom_range(0, 16'hFFFF));
        end
        default: apply_config($urandom_range(0, ONE_Q), $urandom_range(ONE_Q / 2, 4 * ONE_Q),
                              $urandom_range(ONE_Q / 2, 4 * ONE_Q));
      endcase
      // one stretch with no idling on either side, and the long hold-off
      quiet_phase <= (phase == 2);
      if (phase == 2) begin
        hold_req <= 1'b1;
      end

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if (phase == 0 && phase_items == 0) begin
          n = $urandom_range(int'(POS_MAX) + 1, int'(POS_MAX) + 35);
        end else if (phase == 3 && phase_items == 0) begin
          n = FIRST_CLASS + MAX_CLASSES + $urandom_range(0, 3);
        end else if ($urandom_range(99) < 8) begin
          n = $urandom_range(1, OBJ_POS);
        end else begin
          n = FIRST_CLASS + $urandom_range(0, 12);
        end

        row_buf.delete();
        for (int i = 0; i < n; i++) begin
          if (i < OBJ_POS) begin
            row_buf = {row_buf, box_elem()};
          end else if (i == OBJ_POS) begin
            row_buf = {row_buf, obj_elem(cur_thr)};
          end else if (i < FIRST_CLASS + MAX_CLASSES - 2) begin
            row_buf = {row_buf, score_elem()};
          end else begin
            // top classes and the ignored tail get the full range
            row_buf = {row_buf, wild_elem()};
          end
        end
        send_row();
        phase_items += n;
      end
    end

    wait_drained();
    $display("run covered %0d elements in %0d rows over %0d register settings",
             elements_sent, rows_sent, settings_used);
    $display("%0d detections compared field by field, %0d rows fell below threshold",
             dets_checked, rows_dropped);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/yrd_pkg.sv
rtl/core/yrd_front.sv
rtl/core/yrd_queue.sv
rtl/core/yrd_back.sv
rtl/core/yolo_row_decode_core.sv
test/row_decode_compare.sv
test/yolo_row_decode_core_test.sv
